// ----- hdl/f64add_pkg.sv -----
// Constants and types shared by the binary64 adder.
package f64add_pkg;

  localparam int unsigned FracW  = 52;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned GuardW = 3;
  localparam int unsigned MantW  = 57;   // carry, hidden, fraction, guard bits
  localparam int unsigned LzcW   = 6;

  localparam logic [ExpW-1:0] ExpAllOnes = 11'h7ff;
  localparam logic [63:0] DefaultNan = 64'h7ff8_0000_0000_0000;
  localparam logic [62:0] MaxFinite  = 63'h7fef_ffff_ffff_ffff;

  typedef struct packed {
    logic        special;
    logic [63:0] spec_bits;
    logic        spec_inv;
    logic        same;
    logic        sign;
    logic [ExpW-1:0] exp_big;
    logic [ExpW-1:0] exp_small;
    logic [MantW-1:0] sig_big;
    logic [MantW-1:0] sig_small;
  } s1_t;

  typedef struct packed {
    logic        special;
    logic [63:0] spec_bits;
    logic        spec_inv;
    logic        same;
    logic        sign;
    logic [ExpW-1:0] exp_big;
    logic [MantW-1:0] mant;
  } s2_t;

  typedef struct packed {
    logic        special;
    logic [63:0] spec_bits;
    logic        spec_inv;
    logic        same;
    logic        sign;
    logic        zero;
    logic [ExpW:0] exp_n;
    logic [MantW-2:0] mant_n;
  } s3_t;

  typedef struct packed {
    logic [63:0] sum_bits;
    logic        invalid_flag;
    logic        overflow_flag;
    logic        inexact_flag;
  } res_t;

  function automatic logic [LzcW-1:0] lzc56(input logic [MantW-2:0] v);
    logic [LzcW-1:0] n;
    logic            found;
    n = LzcW'(MantW - 1);
    found = 1'b0;
    for (int i = MantW - 2; i >= 0; i--) begin
      if (v[i] && !found) begin
        n = LzcW'(MantW - 2 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ----- hdl/binary64_float_adder_top.sv -----
// Four-stage binary64 adder/subtractor, round toward zero.
//
// channel  dir  tdata bits                                         tuser
// s_axis   in   [63:0] operand_a, [127:64] operand_b               req_type
// m_axis   out  [63:0] sum_bits, [64] invalid, [65] ovf, [66] inx  -
//
// One transfer per cycle sustained while m_axis_tready stays high.
// Stages: unpack/compare, align and add, leading-zero count and normalise, pack.
// Reset clears the stage valid bits only.
// A stall on m_axis holds every stage whose successor is full; nothing is lost.
module binary64_float_adder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // operand_a, operand_b
  input  logic         s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata    // sum_bits, invalid, overflow, inexact, zero pad
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  f64add_pkg::s1_t  s1_d, s1_q;
  f64add_pkg::s2_t  s2_d, s2_q;
  f64add_pkg::s3_t  s3_d, s3_q;
  f64add_pkg::res_t s4_d, s4_q;

  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  // stage 1: classify, order by magnitude
  always_comb begin
    logic [63:0] a, b, be, big, sml;
    logic a_nan, b_nan, a_inf, b_inf;
    logic [10:0] eb, es;
    a = s_axis_tdata[63:0];
    b = s_axis_tdata[127:64];
    be = {b[63] ^ s_axis_tuser, b[62:0]};
    a_nan = (a[62:52] == f64add_pkg::ExpAllOnes) && (a[51:0] != '0);
    b_nan = (b[62:52] == f64add_pkg::ExpAllOnes) && (b[51:0] != '0);
    a_inf = (a[62:52] == f64add_pkg::ExpAllOnes) && (a[51:0] == '0);
    b_inf = (b[62:52] == f64add_pkg::ExpAllOnes) && (b[51:0] == '0);
    if (be[62:0] > a[62:0]) begin
      big = be;
      sml = a;
    end else begin
      big = a;
      sml = be;
    end
    eb = (big[62:52] == '0) ? 11'd1 : big[62:52];
    es = (sml[62:52] == '0) ? 11'd1 : sml[62:52];
    s1_d.special   = a_nan || b_nan || a_inf || b_inf;
    s1_d.spec_inv  = 1'b0;
    s1_d.spec_bits = '0;
    if (a_nan || b_nan) begin
      s1_d.spec_inv  = (a_nan && !a[51]) || (b_nan && !b[51]);
      s1_d.spec_bits = (a_nan ? a : b) | 64'h0008_0000_0000_0000;
    end else if (a_inf && b_inf && (a[63] != be[63])) begin
      s1_d.spec_inv  = 1'b1;
      s1_d.spec_bits = f64add_pkg::DefaultNan;
    end else begin
      s1_d.spec_bits = a_inf ? a : be;
    end
    s1_d.same      = (big[63] == sml[63]);
    s1_d.sign      = big[63];
    s1_d.exp_big   = eb;
    s1_d.exp_small = es;
    s1_d.sig_big   = {1'b0, big[62:52] != '0, big[51:0], 3'b000};
    s1_d.sig_small = {1'b0, sml[62:52] != '0, sml[51:0], 3'b000};
  end

  // stage 2: align with sticky, then add or subtract
  always_comb begin
    logic [10:0] d;
    logic [56:0] ms, lost_mask;
    d = s1_q.exp_big - s1_q.exp_small;
    ms = s1_q.sig_small;
    lost_mask = ~(57'h1ff_ffff_ffff_ffff << d[5:0]);
    if (d >= 11'd60) begin
      ms = {56'd0, s1_q.sig_small != '0};
    end else if (d != '0) begin
      ms = (s1_q.sig_small >> d[5:0]) | {56'd0, (s1_q.sig_small & lost_mask) != '0};
    end
    s2_d.special   = s1_q.special;
    s2_d.spec_bits = s1_q.spec_bits;
    s2_d.spec_inv  = s1_q.spec_inv;
    s2_d.same      = s1_q.same;
    s2_d.sign      = s1_q.sign;
    s2_d.exp_big   = s1_q.exp_big;
    s2_d.mant      = s1_q.same ? s1_q.sig_big + ms : s1_q.sig_big - ms;
  end

  // stage 3: carry fold, leading-zero count, left shift
  always_comb begin
    logic [55:0] m;
    logic [11:0] e;
    logic [5:0]  lz, sh;
    if (s2_q.mant[56]) begin
      m = {s2_q.mant[56:2], s2_q.mant[1] | s2_q.mant[0]};
      e = {1'b0, s2_q.exp_big} + 12'd1;
    end else begin
      m = s2_q.mant[55:0];
      e = {1'b0, s2_q.exp_big};
    end
    lz = f64add_pkg::lzc56(m);
    sh = (12'(lz) < e) ? lz : 6'(e - 12'd1);
    s3_d.special   = s2_q.special;
    s3_d.spec_bits = s2_q.spec_bits;
    s3_d.spec_inv  = s2_q.spec_inv;
    s3_d.same      = s2_q.same;
    s3_d.sign      = s2_q.sign;
    s3_d.zero      = (s2_q.mant == '0);
    s3_d.exp_n     = e - 12'(sh);
    s3_d.mant_n    = m << sh;
  end

  // stage 4: pack
  always_comb begin
    logic [52:0] frac;
    s4_d = '0;
    frac = s3_q.mant_n[55:3];
    if (s3_q.special) begin
      s4_d.sum_bits     = s3_q.spec_bits;
      s4_d.invalid_flag = s3_q.spec_inv;
    end else if (s3_q.zero) begin
      s4_d.sum_bits = {s3_q.same & s3_q.sign, 63'd0};
    end else if (s3_q.exp_n >= 12'd2047) begin
      s4_d.sum_bits      = {s3_q.sign, f64add_pkg::MaxFinite};
      s4_d.overflow_flag = 1'b1;
      s4_d.inexact_flag  = 1'b1;
    end else begin
      s4_d.inexact_flag = (s3_q.mant_n[2:0] != '0);
      s4_d.sum_bits = {s3_q.sign, frac[52] ? s3_q.exp_n[10:0] : 11'd0, frac[51:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {5'd0, s4_q.inexact_flag, s4_q.overflow_flag, s4_q.invalid_flag,
                          s4_q.sum_bits};

endmodule
